>>> sv/sobel_vertical_edge_rgb_core_macros.svh
// Assertion macros for the vertical-edge Sobel core.
// Included by the top level; no other dependencies.
`ifndef SOBEL_VERTICAL_EDGE_RGB_CORE_MACROS_SVH
`define SOBEL_VERTICAL_EDGE_RGB_CORE_MACROS_SVH

// same-cycle implication
`define SVER_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sver assertion failed");

// next-cycle implication
`define SVER_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sver assertion failed");

`endif

>>> sv/sver_pkg.sv
// Shared types and constants for the vertical-edge Sobel core.
// No dependencies.
package sver_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_WIDTH     = 640;
   localparam int DEF_HEIGHT    = 480;
   localparam int CSR_WIDTH_W   = 11;
   localparam int CSR_HEIGHT_W  = 16;
   localparam int PIX_W         = 24;
   localparam int FIFO_DEPTH    = 4;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic       frame_last;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rsp_item_type;

endpackage

>>> sv/sobel_vertical_edge_rgb_core.sv
// Vertical-edge Sobel filter on a raster RGB pixel stream.
// Depends on sver_pkg, sver_line_ram, sver_out_fifo and the assertion macros.
//
// Usage:
//   req_* takes one pixel per transfer in raster order; req_tuser high marks
//   the first pixel of a frame and clears the row/column position.
//   rsp_* gives one result per interior pixel (border pixels give none), in
//   raster order; rsp_tlast marks the last interior pixel of the frame.
//   csr_* writes image_width (index 0) and image_height (index 1); write only
//   while no pixel is in flight. Width is clamped to 3..MAX_WIDTH, height to
//   at least 3.
// Throughput: one pixel per cycle while req_tready is high, set by the single
//   read-modify-write of the line RAM per pixel (read at accept, write in the
//   cycle after, with a forwarding path for back-to-back hits on the same entry).
// Result path: the transfer of the pixel one row below and one column right
//   of a result's center is registered into stage 1, which pushes the result
//   into the queue; rsp_tvalid follows from the queue's registered count.
// Reset: counters and window clear, sizes return to 640 x 480, the queue
//   empties. The line RAM is not cleared.
// Stall: a 4-entry result queue absorbs the pipeline; req_tready drops once
//   three results wait, so nothing is lost while rsp_tready is low.
module sobel_vertical_edge_rgb_core #(
   parameter int MAX_WIDTH = sver_pkg::DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out, green_out, blue_out
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CNTW = $clog2(MAX_WIDTH);
   localparam int WCW  = ($clog2(MAX_WIDTH + 1) > sver_pkg::CSR_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : sver_pkg::CSR_WIDTH_W;
   localparam int HW   = sver_pkg::CSR_HEIGHT_W;
   localparam int PXW  = sver_pkg::PIX_W;
   localparam int QCW  = $clog2(sver_pkg::FIFO_DEPTH + 1);

   function automatic logic [7:0] sobel_chan(input logic [7:0] lt, input logic [7:0] lm,
                                             input logic [7:0] lb, input logic [7:0] rt,
                                             input logic [7:0] rm, input logic [7:0] rb);
      logic [9:0]  lsum;
      logic [9:0]  rsum;
      logic [10:0] diff;
      lsum = {2'b00, lt} + {1'b0, lm, 1'b0} + {2'b00, lb};
      rsum = {2'b00, rt} + {1'b0, rm, 1'b0} + {2'b00, rb};
      diff = {1'b0, lsum} - {1'b0, rsum};
      if (diff[10]) begin
         diff = -diff;
      end
      return (diff > 11'd255) ? 8'hFF : diff[7:0];
   endfunction

   // configuration
   logic [sver_pkg::CSR_WIDTH_W-1:0] width_ff;
   logic [HW-1:0]                    height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sver_pkg::CSR_WIDTH_W'(sver_pkg::DEF_WIDTH);
         height_ff <= HW'(sver_pkg::DEF_HEIGHT);
      end else if (csr_wen) begin
         case (csr_index)
            sver_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[sver_pkg::CSR_WIDTH_W-1:0];
            end
            sver_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // stage 0: position and line RAM read
   logic [CNTW-1:0] col_ff, col_in, col_e;
   logic [HW-1:0]   row_ff, row_in, row_e;
   logic [WCW-1:0]  w_ext, w_use, w_last;
   logic [HW-1:0]   h_use, h_last;
   logic            col_end, row_end, emit0, accept;
   logic [QCW-1:0]  q_count;

   always_comb begin
      w_ext = WCW'(width_ff);
      if (w_ext < WCW'(3)) begin
         w_use = WCW'(3);
      end else if (w_ext > WCW'(MAX_WIDTH)) begin
         w_use = WCW'(MAX_WIDTH);
      end else begin
         w_use = w_ext;
      end
      w_last  = w_use - WCW'(1);
      h_use   = (height_ff < HW'(3)) ? HW'(3) : height_ff;
      h_last  = h_use - HW'(1);
      col_e   = req_tuser ? '0 : col_ff;
      row_e   = req_tuser ? '0 : row_ff;
      col_end = (WCW'(col_e) >= w_last);
      row_end = (row_e >= h_last);
      emit0   = (row_e >= HW'(2)) && (col_e >= CNTW'(2));
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_e + HW'(1);
      end else begin
         col_in = col_e + CNTW'(1);
         row_in = row_e;
      end
   end

   assign req_tready = (q_count < QCW'(sver_pkg::FIFO_DEPTH - 1));
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: entry resolve, write-back, window and filter
   logic                 s1_v_ff, s1_emit_ff, s1_last_ff, hit_ff, hit_in;
   logic [PXW-1:0]       s1_px_ff;
   logic [CNTW-1:0]      s1_addr_ff;
   logic [2*PXW-1:0]     fwd_ff, rd_data, entry;
   logic [PXW-1:0]       top, mid;
   logic [PXW-1:0]       win_ff [6];
   sver_pkg::rsp_item_type s1_item;
   logic                 push, pop;
   sver_pkg::rsp_item_type q_item;

   assign hit_in = accept && s1_v_ff && (col_e == s1_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         hit_ff  <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit0;
         s1_last_ff <= col_end && row_end;
         s1_px_ff   <= req_tdata;
         s1_addr_ff <= col_e;
      end
      fwd_ff <= {mid, s1_px_ff};
   end

   sver_line_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (2 * PXW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_v_ff),
      .wr_addr (s1_addr_ff),
      .wr_data ({mid, s1_px_ff}),
      .rd_en   (accept),
      .rd_addr (col_e),
      .rd_data (rd_data)
   );

   assign entry = hit_ff ? fwd_ff : rd_data;
   assign top   = entry[2*PXW-1:PXW];
   assign mid   = entry[PXW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_v_ff) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top;
         win_ff[1] <= mid;
         win_ff[2] <= s1_px_ff;
      end
   end

   always_comb begin
      s1_item.red        = sobel_chan(win_ff[3][7:0], win_ff[4][7:0], win_ff[5][7:0],
                                      top[7:0], mid[7:0], s1_px_ff[7:0]);
      s1_item.green      = sobel_chan(win_ff[3][15:8], win_ff[4][15:8], win_ff[5][15:8],
                                      top[15:8], mid[15:8], s1_px_ff[15:8]);
      s1_item.blue       = sobel_chan(win_ff[3][23:16], win_ff[4][23:16], win_ff[5][23:16],
                                      top[23:16], mid[23:16], s1_px_ff[23:16]);
      s1_item.frame_last = s1_last_ff;
   end

   assign push = s1_v_ff && s1_emit_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   sver_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (s1_item),
      .pop       (pop),
      .pop_item  (q_item),
      .nonempty  (rsp_tvalid),
      .count     (q_count)
   );

   assign rsp_tdata = {q_item.blue, q_item.green, q_item.red};
   assign rsp_tlast = q_item.frame_last;

   `include "sobel_vertical_edge_rgb_core_macros.svh"

   `SVER_ASSERT_IMPL(a_queue_no_overflow, push && !pop,
                     q_count < QCW'(sver_pkg::FIFO_DEPTH))
   `SVER_ASSERT_NEXT(a_accept_reaches_s1, accept, s1_v_ff)
   `SVER_ASSERT_IMPL(a_forward_needs_writer, hit_ff, $past(s1_v_ff))

endmodule

>>> sv/sver_line_ram.sv
// Line store RAM: one write port, one read port, registered read data.
// Uses no package.
module sver_line_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sver_out_fifo.sv
// Result queue between the filter stage and the result channel.
// Depends on sver_pkg (rsp_item_type, FIFO_DEPTH).
module sver_out_fifo (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push,
   input  sver_pkg::rsp_item_type                   push_item,
   input  logic                                     pop,
   output sver_pkg::rsp_item_type                   pop_item,
   output logic                                     nonempty,
   output logic [$clog2(sver_pkg::FIFO_DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(sver_pkg::FIFO_DEPTH);
   localparam int CW = $clog2(sver_pkg::FIFO_DEPTH + 1);

   sver_pkg::rsp_item_type entry_ff [sver_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = entry_ff[rd_ptr_ff];
   assign nonempty = (count_ff != '0);
   assign count    = count_ff;

endmodule
